/* sv/cclt_pkg.sv */
// Shared types and constants for the chunk cache.
package cclt_pkg;

  localparam int unsigned Slots = 64;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam logic [3:0] ShiftMax = 4'd8;

  localparam logic [0:0] OpAccess = 1'b0;
  localparam logic [0:0] OpFlush  = 1'b1;

  localparam logic [0:0] RegChunkShift = 1'b0;
  localparam logic [0:0] RegCountLimit = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] voxel_x;
    logic [31:0] voxel_y;
    logic [31:0] voxel_z;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic [31:0] chunk_x;
    logic [31:0] chunk_y;
    logic [31:0] chunk_z;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [7:0]  offset_z;
    logic        evicted;
    logic [31:0] evicted_x;
    logic [31:0] evicted_y;
    logic [31:0] evicted_z;
  } rsp_t;

  // One entry of the tag memory.
  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [31:0] stamp;
  } entry_t;

endpackage

/* sv/cclt_if.sv */
// Valid/ready channel carrying one payload beat.
interface cclt_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/cclt_mem.sv */
// Tag and timestamp memory, one read and one write port, registered read.
module cclt_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [cclt_pkg::SlotW-1:0] waddr_i,
  input  cclt_pkg::entry_t          wdata_i,
  input  logic [cclt_pkg::SlotW-1:0] raddr_i,
  output cclt_pkg::entry_t          rdata_o
);
  cclt_pkg::entry_t mem_q [cclt_pkg::Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/chunk_cache_lru_timestamp.sv */
// Top level of the chunk cache with timestamp LRU replacement.
// An access sweeps the tag memory one slot a cycle through the single read port
// of the tag memory; the result goes to the output register in the write-back
// stage after the sweep, and no new beat is taken until the cache is idle again.
// A flush goes from idle straight to the write-back stage; a full output register
// holds the write-back stage. Reset clears valid bits, counters and registers only.
module chunk_cache_lru_timestamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  cclt_if.sink        req,
  cclt_if.source      rsp
);
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StWrite = 2'd2;

  localparam int unsigned SW = cclt_pkg::SlotW;

  logic [1:0]  state_q, state_d;
  logic [3:0]  shift_q;
  logic [6:0]  limit_q;
  logic [cclt_pkg::Slots-1:0] valid_q;
  logic [31:0] stamp_q;
  logic [cclt_pkg::CntW-1:0] count_q;

  // Per-item working registers.
  logic [31:0] cx_q, cy_q, cz_q;
  logic [7:0]  ox_q, oy_q, oz_q;
  logic        flush_q;
  logic [SW:0] rd_q;      // next slot address to issue
  logic [SW-1:0] cmp_q;   // slot whose data arrives this cycle
  logic        cmp_v_q;
  logic        hit_q;
  logic [SW-1:0] hslot_q;
  logic        free_q;
  logic [SW-1:0] fslot_q;
  logic        vv_q;      // victim among valid entries
  logic [SW-1:0] vslot_q;
  logic [31:0] vstamp_q;
  cclt_pkg::entry_t vent_q;
  logic [SW-1:0] aslot_q;
  logic [31:0] astamp_q;
  cclt_pkg::entry_t aent_q;
  logic        out_v_q;
  cclt_pkg::rsp_t out_q;

  logic        mem_we;
  logic [SW-1:0] mem_wa;
  cclt_pkg::entry_t mem_wd;
  cclt_pkg::entry_t mem_rd;

  cclt_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_wa),
    .wdata_i(mem_wd),
    .raddr_i(rd_q[SW-1:0]),
    .rdata_o(mem_rd)
  );

  logic [3:0]  s_eff;
  logic [31:0] mask;
  logic        acc;
  logic [31:0] stamp_n;
  logic        tag_eq;
  logic        wr_go;

  assign s_eff   = (shift_q > cclt_pkg::ShiftMax) ? cclt_pkg::ShiftMax : shift_q;
  assign mask    = (32'd1 << s_eff) - 32'd1;
  assign acc     = req.valid && req.ready;
  assign stamp_n = stamp_q + 32'd1;
  assign tag_eq  = (mem_rd.tx == cx_q) && (mem_rd.ty == cy_q) && (mem_rd.tz == cz_q);
  // Write back only once the output register is free or being emptied.
  assign wr_go   = (state_q == StWrite) && (!out_v_q || rsp.ready);
  assign req.ready = (state_q == StIdle);
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (acc) state_d = (req.data.op == cclt_pkg::OpFlush) ? StWrite : StScan;
      StScan:  if (cmp_v_q && cmp_q == SW'(cclt_pkg::Slots - 1)) state_d = StWrite;
      StWrite: if (wr_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Decide the outcome of the sweep.
  logic        do_ins, do_ev;
  logic [SW-1:0] wslot;
  logic [cclt_pkg::CntW:0] cnt_new;
  always_comb begin
    cnt_new = {1'b0, count_q} + 1'b1;
    do_ins = !hit_q && free_q;
    do_ev  = do_ins && (cnt_new >= (cclt_pkg::CntW+1)'(limit_q)) && vv_q;
    wslot  = hit_q ? hslot_q : (free_q ? fslot_q : aslot_q);
    mem_we = wr_go && !flush_q;
    mem_wa = wslot;
    mem_wd = '{tx: cx_q, ty: cy_q, tz: cz_q, stamp: stamp_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      shift_q <= 4'd5;
      limit_q <= 7'd64;
      valid_q <= '0;
      stamp_q <= '0;
      count_q <= '0;
      out_v_q <= 1'b0;
      rd_q    <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cclt_pkg::RegChunkShift: shift_q <= cfg_data_i[3:0];
          cclt_pkg::RegCountLimit: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      // Issue reads one slot a cycle; compare the slot read the cycle before.
      cmp_v_q <= (state_q == StScan) && !rd_q[SW];
      if (state_q == StScan && !rd_q[SW]) rd_q <= rd_q + 1'b1;
      if (acc) begin
        rd_q <= '0;
        if (req.data.op == cclt_pkg::OpFlush) begin
          valid_q <= '0;
          count_q <= '0;
        end else begin
          stamp_q <= stamp_n;
        end
      end
      if (wr_go) begin
        if (!flush_q && !hit_q) begin
          valid_q[wslot] <= 1'b1;
          if (do_ins) count_q <= do_ev ? count_q : cnt_new[cclt_pkg::CntW-1:0];
          if (do_ev) valid_q[vslot_q] <= 1'b0;
        end
        out_v_q <= 1'b1;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cx_q <= $signed(req.data.voxel_x) >>> s_eff;
      cy_q <= $signed(req.data.voxel_y) >>> s_eff;
      cz_q <= $signed(req.data.voxel_z) >>> s_eff;
      ox_q <= 8'(req.data.voxel_x & mask);
      oy_q <= 8'(req.data.voxel_y & mask);
      oz_q <= 8'(req.data.voxel_z & mask);
      flush_q <= (req.data.op == cclt_pkg::OpFlush);
      hit_q <= 1'b0;
      free_q <= 1'b0;
      vv_q  <= 1'b0;
      hslot_q <= '0;
      fslot_q <= '0;
      vslot_q <= '0;
      aslot_q <= '0;
      vstamp_q <= stamp_n;
      astamp_q <= '1;
      vent_q <= '0;
      aent_q <= '0;
      cmp_q  <= '0;
    end
    if (state_q == StScan) cmp_q <= rd_q[SW-1:0];
    if (cmp_v_q) begin
      // Hit search over valid entries; first match wins.
      if (valid_q[cmp_q] && tag_eq && !hit_q) begin
        hit_q <= 1'b1;
        hslot_q <= cmp_q;
      end
      if (!valid_q[cmp_q] && !free_q) begin
        free_q <= 1'b1;
        fslot_q <= cmp_q;
      end
      // Oldest valid entry strictly below the new counter.
      if (valid_q[cmp_q] && mem_rd.stamp < vstamp_q) begin
        vv_q <= 1'b1;
        vslot_q <= cmp_q;
        vstamp_q <= mem_rd.stamp;
        vent_q <= mem_rd;
      end
      // Oldest entry overall, for a full store; slot 0 stands until an older one.
      if ((mem_rd.stamp < astamp_q) || (cmp_q == '0)) begin
        aslot_q <= cmp_q;
        astamp_q <= mem_rd.stamp;
        aent_q <= mem_rd;
      end
    end
    if (wr_go) begin
      if (flush_q) begin
        out_q <= '0;
      end else begin
        out_q.hit <= hit_q;
        out_q.slot <= 6'(wslot);
        out_q.chunk_x <= cx_q;
        out_q.chunk_y <= cy_q;
        out_q.chunk_z <= cz_q;
        out_q.offset_x <= ox_q;
        out_q.offset_y <= oy_q;
        out_q.offset_z <= oz_q;
        if (do_ev) begin
          out_q.evicted <= 1'b1;
          out_q.evicted_x <= vent_q.tx;
          out_q.evicted_y <= vent_q.ty;
          out_q.evicted_z <= vent_q.tz;
        end else if (!hit_q && !free_q) begin
          out_q.evicted <= 1'b1;
          out_q.evicted_x <= aent_q.tx;
          out_q.evicted_y <= aent_q.ty;
          out_q.evicted_z <= aent_q.tz;
        end else begin
          out_q.evicted <= 1'b0;
          out_q.evicted_x <= 32'd0;
          out_q.evicted_y <= 32'd0;
          out_q.evicted_z <= 32'd0;
        end
      end
    end
  end
endmodule

/* test/tb_cclt_checker.sv */
// Scoreboard for the chunk cache: tracks the tag store, predicts each result and compares it.
module tb_cclt_checker
  import cclt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_data_i,
  output int          err_cnt_o,
  output int          outstanding_o
);

  logic [3:0]  shift_q;
  logic [6:0]  limit_q;
  logic        resident_q [Slots];
  logic [31:0] tag_x_q [Slots];
  logic [31:0] tag_y_q [Slots];
  logic [31:0] tag_z_q [Slots];
  logic [31:0] stamp_q [Slots];
  logic [31:0] stamp_ctr_q;
  logic [31:0] resident_cnt_q;
  rsp_t        lookups_q [$];
  int          errs;

  // Advance the tag store by one beat and return the result it should produce.
  function automatic rsp_t cache_lookup(req_t r);
    rsp_t        res;
    int unsigned s;
    logic [31:0] mask, cx, cy, cz, best;
    int          slot, victim;
    bit          hit, found, ev;
    res = '0;
    slot = 0;
    victim = 0;
    hit = 0;
    found = 0;
    ev = 0;
    if (r.op == OpFlush) begin
      for (int i = 0; i < Slots; i++) resident_q[i] = 1'b0;
      resident_cnt_q = 0;
      return res;
    end
    s = (shift_q > ShiftMax) ? ShiftMax : shift_q;
    mask = (32'd1 << s) - 32'd1;
    cx = $signed(r.voxel_x) >>> s;
    cy = $signed(r.voxel_y) >>> s;
    cz = $signed(r.voxel_z) >>> s;
    for (int i = 0; i < Slots; i++) begin
      if (!hit && resident_q[i] && tag_x_q[i] == cx && tag_y_q[i] == cy &&
          tag_z_q[i] == cz) begin
        hit = 1;
        slot = i;
      end
    end
    stamp_ctr_q = stamp_ctr_q + 32'd1;
    if (hit) begin
      stamp_q[slot] = stamp_ctr_q;
    end else begin
      for (int i = 0; i < Slots; i++) begin
        if (!found && !resident_q[i]) begin
          found = 1;
          slot = i;
        end
      end
      if (found) begin
        resident_q[slot] = 1'b1;
        tag_x_q[slot] = cx;
        tag_y_q[slot] = cy;
        tag_z_q[slot] = cz;
        stamp_q[slot] = stamp_ctr_q;
        resident_cnt_q = resident_cnt_q + 1;
        if (resident_cnt_q >= {25'd0, limit_q}) begin
          best = stamp_ctr_q;
          for (int i = 0; i < Slots; i++) begin
            if (resident_q[i] && stamp_q[i] < best) begin
              best = stamp_q[i];
              victim = i;
              ev = 1;
            end
          end
          if (ev) begin
            res.evicted_x = tag_x_q[victim];
            res.evicted_y = tag_y_q[victim];
            res.evicted_z = tag_z_q[victim];
            resident_q[victim] = 1'b0;
            resident_cnt_q = resident_cnt_q - 1;
          end
        end
      end else begin
        // Store full: overwrite the oldest entry in place, count unchanged.
        best = 32'hFFFF_FFFF;
        for (int i = 0; i < Slots; i++) begin
          if (stamp_q[i] < best) begin
            best = stamp_q[i];
            victim = i;
          end
        end
        ev = 1;
        res.evicted_x = tag_x_q[victim];
        res.evicted_y = tag_y_q[victim];
        res.evicted_z = tag_z_q[victim];
        slot = victim;
        tag_x_q[slot] = cx;
        tag_y_q[slot] = cy;
        tag_z_q[slot] = cz;
        stamp_q[slot] = stamp_ctr_q;
      end
    end
    res.hit = hit;
    res.slot = slot[5:0];
    res.chunk_x = cx;
    res.chunk_y = cy;
    res.chunk_z = cz;
    res.offset_x = r.voxel_x[7:0] & mask[7:0];
    res.offset_y = r.voxel_y[7:0] & mask[7:0];
    res.offset_z = r.voxel_z[7:0] & mask[7:0];
    res.evicted = ev;
    return res;
  endfunction

  function automatic int field_diffs(rsp_t e, rsp_t a);
    return int'(e.hit !== a.hit) + int'(e.slot !== a.slot) +
           int'(e.chunk_x !== a.chunk_x) + int'(e.chunk_y !== a.chunk_y) +
           int'(e.chunk_z !== a.chunk_z) + int'(e.offset_x !== a.offset_x) +
           int'(e.offset_y !== a.offset_y) + int'(e.offset_z !== a.offset_z) +
           int'(e.evicted !== a.evicted) + int'(e.evicted_x !== a.evicted_x) +
           int'(e.evicted_y !== a.evicted_y) + int'(e.evicted_z !== a.evicted_z);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      shift_q = 4'd5;
      limit_q = 7'd64;
      for (int i = 0; i < Slots; i++) begin
        resident_q[i] = 1'b0;
        stamp_q[i] = '0;
      end
      stamp_ctr_q = '0;
      resident_cnt_q = '0;
      lookups_q.delete();
      errs = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegChunkShift) shift_q = cfg_data_i[3:0];
        else limit_q = cfg_data_i;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (lookups_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("checker: unexpected result beat %p", rsp_data_i);
        end else begin
          want = lookups_q.pop_front();
          if (field_diffs(want, rsp_data_i) != 0) begin
            errs++;
            if (errs <= 10) $display("checker: mismatch\n  exp %p\n  got %p", want, rsp_data_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) lookups_q.push_back(cache_lookup(req_data_i));
    end
    err_cnt_o = errs;
    outstanding_o = lookups_q.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the chunk cache testbench: clock, reset, stimulus phases and verdict.
module tb_top;
  import cclt_pkg::*;

  typedef enum logic [1:0] {IdleNone, IdleSrc, IdleSnk, IdleBoth} idle_mode_e;

  localparam int WatchdogLimit = 5000;
  localparam int LongHold = 400;
  localparam int PoolDepth = 96;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [6:0]  cfg_data;
  int          err_cnt;
  int          outstanding;
  idle_mode_e  idle_mode;
  logic [3:0]  cur_shift;
  bit          hold_req;
  bit          hold_done;
  int          hold_cnt;
  int          stall_cyc;
  logic [31:0] pool_x [PoolDepth];
  logic [31:0] pool_y [PoolDepth];
  logic [31:0] pool_z [PoolDepth];
  int          pool_used;

  cclt_if #(.T(req_t)) req_ch ();
  cclt_if #(.T(rsp_t)) rsp_ch ();

  chunk_cache_lru_timestamp u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  tb_cclt_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .req_valid_i   (req_ch.valid),
    .req_ready_i   (req_ch.ready),
    .req_data_i    (req_ch.data),
    .rsp_valid_i   (rsp_ch.valid),
    .rsp_ready_i   (rsp_ch.ready),
    .rsp_data_i    (rsp_ch.data),
    .err_cnt_o     (err_cnt),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: stall by the current mode; on request, hold off once for a long
  // stretch so the cache backs up and stops taking beats.
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LongHold;
      rsp_ch.ready <= 1'b0;
    end else if (idle_mode == IdleSnk) begin
      rsp_ch.ready <= ($urandom_range(99) >= 65);
    end else if (idle_mode == IdleBoth) begin
      rsp_ch.ready <= ($urandom_range(99) >= 25);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= WatchdogLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  // Offer one beat, idling first as the mode asks; return at the falling edge
  // after it was taken, with valid still high.
  task automatic send_beat(req_t beat);
    int gap_pct;
    gap_pct = (idle_mode == IdleSrc) ? 65 : (idle_mode == IdleBoth) ? 25 : 0;
    if ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= beat;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_access(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    req_t beat;
    beat = '{op: OpAccess, voxel_x: x, voxel_y: y, voxel_z: z};
    send_beat(beat);
  endtask

  task automatic send_flush();
    req_t beat;
    beat = '0;
    beat.op = OpFlush;
    beat.voxel_x = $urandom;
    beat.voxel_y = $urandom;
    beat.voxel_z = $urandom;
    send_beat(beat);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Write both registers while the cache is idle.
  task automatic set_config(logic [3:0] shift, logic [6:0] limit);
    drain();
    repeat (80) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= RegChunkShift;
    cfg_data <= {3'd0, shift};
    @(negedge clk_i);
    cfg_idx <= RegCountLimit;
    cfg_data <= limit;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_shift = shift;
  endtask

  function automatic logic [31:0] extreme_coord();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Mostly revisit a pool of chunks so hits, fills and evictions all happen;
  // the rest is flushes, extremes and fully random voxels.
  task automatic send_random();
    int          pick, idx, s;
    logic [31:0] mask;
    pick = $urandom_range(99);
    s = (cur_shift > ShiftMax) ? ShiftMax : cur_shift;
    mask = (32'd1 << s) - 32'd1;
    idx = $urandom_range(pool_used - 1);
    if (pick < 2) begin
      send_flush();
    end else if (pick < 5) begin
      send_access(extreme_coord(), extreme_coord(), extreme_coord());
    end else if (pick < 15) begin
      send_access($urandom, $urandom, $urandom);
    end else begin
      send_access((pool_x[idx] & ~mask) | ($urandom & mask),
                  (pool_y[idx] & ~mask) | ($urandom & mask),
                  (pool_z[idx] & ~mask) | ($urandom & mask));
    end
  endtask

  task automatic run_phase(idle_mode_e mode, int items, int chunks, bit squeeze);
    idle_mode = mode;
    pool_used = chunks;
    for (int i = 0; i < PoolDepth; i++) begin
      pool_x[i] = $urandom;
      pool_y[i] = $urandom;
      pool_z[i] = $urandom;
    end
    if (squeeze) hold_req = 1'b1;
    for (int n = 0; n < items; n++) begin
      send_random();
      // Hold the sender halfway until the cache has answered everything.
      if (squeeze && n == items / 2) drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegChunkShift;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    idle_mode = IdleNone;
    cur_shift = 4'd5;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    stall_cyc = 0;
    pool_used = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, extremes, repeat hits, same chunk at another
    // offset, flush then a miss on a chunk that was resident.
    send_flush();
    send_access(32'h0, 32'h0, 32'h0);
    send_access(32'h0, 32'h0, 32'h0);
    send_access(32'h1F, 32'h1F, 32'h1F);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_001F);
    send_access(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFE0);
    send_access(32'hFFFF_FFE0, 32'hFFFF_FFE0, 32'hFFFF_FFE0);
    send_access(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_access(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_access(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_flush();
    send_access(32'h0, 32'h0, 32'h0);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Chunk side 1, eviction from 32 entries.
    set_config(4'd0, 7'd32);
    run_phase(IdleNone, 250, 48, 1'b0);
    // Widest chunk side, limit equal to the slot count, sender gaps.
    set_config(4'd8, 7'd64);
    run_phase(IdleSrc, 250, 90, 1'b0);
    // Shift beyond the cap, limit above the slot count: store runs full.
    set_config(4'd15, 7'd127);
    run_phase(IdleSnk, 250, 90, 1'b0);
    // Zero limit: every miss evicts while another entry is resident.
    set_config(4'd3, 7'd0);
    run_phase(IdleBoth, 250, 20, 1'b0);
    // Limit of one, with the long receiver hold-off and a full sender pause.
    set_config(4'd7, 7'd1);
    run_phase(IdleNone, 250, 10, 1'b1);

    drain();
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/cclt_pkg.sv
sv/cclt_if.sv
sv/cclt_mem.sv
sv/chunk_cache_lru_timestamp.sv
test/tb_cclt_checker.sv
test/tb_top.sv
